// ----- hw/rtl/ppd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths, types and fixed-point helpers of the plane deflector.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int TSTEP_BITS = WORD_BITS - 1;
    localparam int MUL_A_BITS = WORD_BITS + 2;
    localparam int PROD_BITS  = MUL_A_BITS + WORD_BITS;
    localparam int SUM_BITS   = WORD_BITS + 3;
    localparam int DIV_BITS   = WORD_BITS + FRAC_BITS;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANCHOR_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANCHOR_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANCHOR_Z = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNCE   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TSTEP    = 3'd7;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE_Q    = WORD_BITS'(1) << FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef word_t [2:0] vec_t;

    typedef struct packed {
        vec_t                  nrm;
        vec_t                  anc;
        word_t                 bounce;
        logic [TSTEP_BITS-1:0] tstep;
    } cfg_t;

    // Per-item values that ride alongside the divider.
    typedef struct packed {
        vec_t pos;
        vec_t vel;
        vec_t dir;
        vec_t m;
        logic hit;
        logic den_nonneg;
        logic den_zero;
    } side_t;

    function automatic word_t sat_word(input logic signed [PROD_BITS-1:0] v);
        logic [PROD_BITS-WORD_BITS:0] upper;
        upper = v[PROD_BITS-1:WORD_BITS-1];
        if ((&upper) || !(|upper)) begin
            return v[WORD_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    // Exact product, arithmetic shift (floor), then saturation.
    function automatic word_t mulq(input logic signed [MUL_A_BITS-1:0] a,
                                   input logic signed [WORD_BITS-1:0] b);
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] sh;
        prod = a * b;
        sh   = prod >>> FRAC_BITS;
        return sat_word(sh);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ppd_front.sv -----
// ----------------------------------------------------------------------------
// ppd_front
// Step, plane tests, divisor and reflection products over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire ppd_pkg::cfg_t                          cfg,
    input  wire logic                                   in_valid,
    input  wire ppd_pkg::vec_t                          pos,
    input  wire ppd_pkg::vec_t                          vel,
    output logic                                        out_valid,
    output ppd_pkg::side_t                              side,
    output logic [ppd_pkg::WORD_BITS-2:0]               num_mag,
    output logic [ppd_pkg::WORD_BITS-1:0]               den_mag
);

    localparam int W  = ppd_pkg::WORD_BITS;
    localparam int MA = ppd_pkg::MUL_A_BITS;
    localparam int PB = ppd_pkg::PROD_BITS;
    localparam int SB = ppd_pkg::SUM_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ppd_pkg::vec_t pos1_reg, vel1_reg, dir1_reg, na1_reg, np1_reg;
    ppd_pkg::vec_t pos2_reg, vel2_reg, dir2_reg, moved2_reg, dn2_reg, vn2_reg;
    ppd_pkg::word_t pd2_reg;
    logic signed [SB-1:0] npsum2_reg;
    ppd_pkg::vec_t pos3_reg, vel3_reg, dir3_reg, nm3_reg;
    ppd_pkg::word_t pd3_reg, den3_reg, vd3_reg;
    logic signed [SB-1:0] before3_reg;
    ppd_pkg::side_t side_reg;
    logic [W-2:0] num_reg;
    logic [W-1:0] den_reg;

    logic signed [SB-1:0] after_s4;
    logic signed [W-1:0]  tstep_s;
    ppd_pkg::word_t       num_sat_s4;

    assign tstep_s  = $signed({1'b0, cfg.tstep});
    assign after_s4 = SB'($signed(nm3_reg[0])) + SB'($signed(nm3_reg[1]))
                    + SB'($signed(nm3_reg[2])) + SB'(pd3_reg);
    assign num_sat_s4 = ppd_pkg::sat_word(PB'(before3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: step and the products with the normal.
        pos1_reg <= pos;
        vel1_reg <= vel;
        for (int i = 0; i < 3; i++)
        begin
            dir1_reg[i] <= ppd_pkg::mulq(MA'($signed(vel[i])), tstep_s);
            na1_reg[i]  <= ppd_pkg::mulq(MA'($signed(cfg.nrm[i])), $signed(cfg.anc[i]));
            np1_reg[i]  <= ppd_pkg::mulq(MA'($signed(cfg.nrm[i])), $signed(pos[i]));
        end

        // Stage 2: moved point, plane offset, divisor and velocity products.
        pos2_reg <= pos1_reg;
        vel2_reg <= vel1_reg;
        dir2_reg <= dir1_reg;
        pd2_reg  <= ppd_pkg::sat_word(-(PB'($signed(na1_reg[0])) + PB'($signed(na1_reg[1]))
                                       + PB'($signed(na1_reg[2]))));
        npsum2_reg <= SB'($signed(np1_reg[0])) + SB'($signed(np1_reg[1]))
                    + SB'($signed(np1_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            moved2_reg[i] <= ppd_pkg::sat_word(PB'($signed(pos1_reg[i]))
                                             + PB'($signed(dir1_reg[i])));
            dn2_reg[i] <= ppd_pkg::mulq(MA'($signed(dir1_reg[i])), $signed(cfg.nrm[i]));
            vn2_reg[i] <= ppd_pkg::mulq(MA'($signed(vel1_reg[i])), $signed(cfg.nrm[i]));
        end

        // Stage 3: side test before the move, divisor and reflection scale.
        pos3_reg    <= pos2_reg;
        vel3_reg    <= vel2_reg;
        dir3_reg    <= dir2_reg;
        pd3_reg     <= pd2_reg;
        before3_reg <= npsum2_reg + SB'(pd2_reg);
        den3_reg    <= ppd_pkg::sat_word(PB'($signed(dn2_reg[0])) + PB'($signed(dn2_reg[1]))
                                       + PB'($signed(dn2_reg[2])));
        vd3_reg     <= ppd_pkg::sat_word(PB'($signed(vn2_reg[0])) + PB'($signed(vn2_reg[1]))
                                       + PB'($signed(vn2_reg[2])));
        for (int i = 0; i < 3; i++)
        begin
            nm3_reg[i] <= ppd_pkg::mulq(MA'($signed(cfg.nrm[i])), $signed(moved2_reg[i]));
        end

        // Stage 4: crossing test and divider operands.
        side_reg.pos        <= pos3_reg;
        side_reg.vel        <= vel3_reg;
        side_reg.dir        <= dir3_reg;
        side_reg.hit        <= (after_s4 <= 0) && (before3_reg > 0);
        side_reg.den_nonneg <= !den3_reg[W-1];
        side_reg.den_zero   <= (den3_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            side_reg.m[i] <= ppd_pkg::mulq(MA'(vd3_reg), $signed(cfg.nrm[i]));
        end
        num_reg <= num_sat_s4[W-2:0];
        den_reg <= den3_reg[W-1] ? (~den3_reg + 1'b1) : den3_reg;
    end

    assign out_valid = v4_reg;
    assign side      = side_reg;
    assign num_mag   = num_reg;
    assign den_mag   = den_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_div.sv -----
// ----------------------------------------------------------------------------
// ppd_div
// Pipelined restoring divider of the shifted numerator, a few bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic [ppd_pkg::WORD_BITS-2:0]      num,
    input  wire logic [ppd_pkg::WORD_BITS-1:0]      den,
    output logic                                    out_valid,
    output logic [ppd_pkg::DIV_BITS-1:0]            quo
);

    localparam int W  = ppd_pkg::WORD_BITS;
    localparam int DB = ppd_pkg::DIV_BITS;
    localparam int NS = ppd_pkg::DIV_STAGES;
    localparam int ST = ppd_pkg::DIV_STEPS;

    logic          v_reg   [NS];
    logic [DB-1:0] dvd_reg [NS];
    logic [DB-1:0] quo_reg [NS];
    logic [W:0]    rem_reg [NS];
    logic [W-1:0]  den_reg [NS];

    logic          v_in   [NS];
    logic [DB-1:0] dvd_in [NS];
    logic [DB-1:0] quo_in [NS];
    logic [W:0]    rem_in [NS];
    logic [W-1:0]  den_in [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [DB-1:0] dvd_next, quo_next;
        logic [W:0]    rem_next;

        if (s == 0)
        begin : g_first
            assign v_in[s]   = in_valid;
            assign dvd_in[s] = DB'({num, {ppd_pkg::FRAC_BITS{1'b0}}});
            assign quo_in[s] = '0;
            assign rem_in[s] = '0;
            assign den_in[s] = den;
        end
        else
        begin : g_next
            assign v_in[s]   = v_reg[s-1];
            assign dvd_in[s] = dvd_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
            assign rem_in[s] = rem_reg[s-1];
            assign den_in[s] = den_reg[s-1];
        end

        always_comb
        begin
            dvd_next = dvd_in[s];
            quo_next = quo_in[s];
            rem_next = rem_in[s];
            for (int k = 0; k < ST; k++)
            begin
                rem_next = {rem_next[W-1:0], dvd_next[DB-1]};
                dvd_next = dvd_next << 1;
                if (rem_next >= {1'b0, den_in[s]})
                begin
                    rem_next = rem_next - {1'b0, den_in[s]};
                    quo_next = {quo_next[DB-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[DB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            dvd_reg[s] <= dvd_next;
            quo_reg[s] <= quo_next;
            rem_reg[s] <= rem_next;
            den_reg[s] <= den_in[s];
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quo       = quo_reg[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_back.sv -----
// ----------------------------------------------------------------------------
// ppd_back
// Crossing fraction, hit point, bounce scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ppd_pkg::word_t                     bounce,
    input  wire logic                               in_valid,
    input  wire ppd_pkg::side_t                     side,
    input  wire logic [ppd_pkg::DIV_BITS-1:0]       quo,
    output logic                                    done,
    output ppd_pkg::vec_t                           new_pos,
    output ppd_pkg::vec_t                           new_vel,
    output logic                                    deflected
);

    localparam int W  = ppd_pkg::WORD_BITS;
    localparam int DB = ppd_pkg::DIV_BITS;
    localparam int MA = ppd_pkg::MUL_A_BITS;
    localparam int PB = ppd_pkg::PROD_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ppd_pkg::vec_t pos1_reg, vel1_reg, dir1_reg;
    logic hit1_reg, hit2_reg, hit3_reg;
    ppd_pkg::word_t frac1_reg;
    logic signed [MA-1:0] r1_reg [3];
    ppd_pkg::vec_t pos2_reg, vel2_reg, dir2_reg, hp2_reg, vo2_reg;
    ppd_pkg::vec_t pos3_reg, vel3_reg, hp3_reg, q3_reg, vo3_reg;
    ppd_pkg::vec_t new_pos_reg, new_vel_reg;
    logic deflected_reg;

    ppd_pkg::word_t frac_b1;

    // The numerator is negative, so a nonnegative divisor gives a negative fraction.
    always_comb
    begin
        if (side.den_zero)
        begin
            frac_b1 = ppd_pkg::WORD_MAX;
        end
        else if (side.den_nonneg)
        begin
            if ((|quo[DB-1:W]) || (quo[W-1] && (|quo[W-2:0])))
            begin
                frac_b1 = ppd_pkg::WORD_MIN;
            end
            else
            begin
                frac_b1 = -$signed(quo[W-1:0]);
            end
        end
        else if (|quo[DB-1:W-1])
        begin
            frac_b1 = ppd_pkg::WORD_MAX;
        end
        else
        begin
            frac_b1 = $signed(quo[W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos1_reg  <= side.pos;
        vel1_reg  <= side.vel;
        dir1_reg  <= side.dir;
        hit1_reg  <= side.hit;
        frac1_reg <= frac_b1;
        for (int i = 0; i < 3; i++)
        begin
            r1_reg[i] <= MA'($signed(side.vel[i])) - (MA'($signed(side.m[i])) <<< 1);
        end

        pos2_reg <= pos1_reg;
        vel2_reg <= vel1_reg;
        dir2_reg <= dir1_reg;
        hit2_reg <= hit1_reg;
        for (int i = 0; i < 3; i++)
        begin
            hp2_reg[i] <= ppd_pkg::mulq(MA'($signed(dir1_reg[i])), frac1_reg);
            vo2_reg[i] <= ppd_pkg::mulq(r1_reg[i], bounce);
        end

        pos3_reg <= pos2_reg;
        vel3_reg <= vel2_reg;
        hp3_reg  <= hp2_reg;
        vo3_reg  <= vo2_reg;
        hit3_reg <= hit2_reg;
        for (int i = 0; i < 3; i++)
        begin
            q3_reg[i] <= ppd_pkg::mulq(MA'($signed(hp2_reg[i])) - MA'($signed(dir2_reg[i])),
                                       bounce);
        end

        deflected_reg <= hit3_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (hit3_reg)
            begin
                new_pos_reg[i] <= ppd_pkg::sat_word(PB'($signed(pos3_reg[i]))
                                                  + PB'($signed(hp3_reg[i]))
                                                  + PB'($signed(q3_reg[i])));
                new_vel_reg[i] <= vo3_reg[i];
            end
            else
            begin
                new_pos_reg[i] <= pos3_reg[i];
                new_vel_reg[i] <= vel3_reg[i];
            end
        end
    end

    assign done      = v4_reg;
    assign new_pos   = new_pos_reg;
    assign new_vel   = new_vel_reg;
    assign deflected = deflected_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/particle_plane_deflector.sv -----
// ----------------------------------------------------------------------------
// particle_plane_deflector
// Deflects one Q16.16 particle per cycle off a configured plane.
// ----------------------------------------------------------------------------
// A particle is transferred in at a rising edge with start high and busy low.
// busy never rises, so a particle can be given in every cycle.
// Each result is shown with done high for one cycle, together with new_pos_*, new_vel_*
// and deflected; results come out in the order the particles went in.
// The pipeline holds four stages of step, plane tests and dot products, twelve
// divider stages at four quotient bits each, and four stages for the hit
// point, bounce scaling and the output register.
// The receiver cannot stall; each result must be taken in its done cycle.
// Configuration is a separate write channel: cfg_index selects the register
// in the order normal x/y/z, anchor x/y/z, bounce factor, time step, and
// cfg_ready is always high. Write it only while no particle is in flight.
// Reset clears the pipeline and loads the register defaults: normal (0,1,0),
// anchor at the origin, bounce factor and time step zero.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_plane_deflector (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   pos_x,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   pos_y,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   pos_z,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   vel_x,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   vel_y,
    input  wire logic signed [ppd_pkg::WORD_BITS-1:0]   vel_z,
    output logic                                        done,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_pos_x,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_pos_y,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_pos_z,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_vel_x,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_vel_y,
    output logic signed [ppd_pkg::WORD_BITS-1:0]        new_vel_z,
    output logic                                        deflected,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ppd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [ppd_pkg::WORD_BITS-1:0]          cfg_data
);

    localparam int NS = ppd_pkg::DIV_STAGES;

    ppd_pkg::cfg_t  cfg_reg;
    ppd_pkg::vec_t  pos_in, vel_in, new_pos, new_vel;
    ppd_pkg::side_t front_side;
    ppd_pkg::side_t side_reg [NS];
    logic           front_valid, div_valid;
    logic [ppd_pkg::WORD_BITS-2:0] num_mag;
    logic [ppd_pkg::WORD_BITS-1:0] den_mag;
    logic [ppd_pkg::DIV_BITS-1:0]  quo;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nrm[0] <= '0;
            cfg_reg.nrm[1] <= ppd_pkg::ONE_Q;
            cfg_reg.nrm[2] <= '0;
            cfg_reg.anc    <= '0;
            cfg_reg.bounce <= '0;
            cfg_reg.tstep  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppd_pkg::CFG_NORMAL_X: cfg_reg.nrm[0] <= cfg_data;
                ppd_pkg::CFG_NORMAL_Y: cfg_reg.nrm[1] <= cfg_data;
                ppd_pkg::CFG_NORMAL_Z: cfg_reg.nrm[2] <= cfg_data;
                ppd_pkg::CFG_ANCHOR_X: cfg_reg.anc[0] <= cfg_data;
                ppd_pkg::CFG_ANCHOR_Y: cfg_reg.anc[1] <= cfg_data;
                ppd_pkg::CFG_ANCHOR_Z: cfg_reg.anc[2] <= cfg_data;
                ppd_pkg::CFG_BOUNCE:   cfg_reg.bounce <= cfg_data;
                ppd_pkg::CFG_TSTEP:    cfg_reg.tstep  <= cfg_data[ppd_pkg::TSTEP_BITS-1:0];
                default:               cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign pos_in = {pos_z, pos_y, pos_x};
    assign vel_in = {vel_z, vel_y, vel_x};

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (start && !busy),
        .pos       (pos_in),
        .vel       (vel_in),
        .out_valid (front_valid),
        .side      (front_side),
        .num_mag   (num_mag),
        .den_mag   (den_mag)
    );

    ppd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .num       (num_mag),
        .den       (den_mag),
        .out_valid (div_valid),
        .quo       (quo)
    );

    // Per-item values wait here while the divider works.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_side;
        for (int s = 1; s < NS; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    ppd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bounce    (cfg_reg.bounce),
        .in_valid  (div_valid),
        .side      (side_reg[NS-1]),
        .quo       (quo),
        .done      (done),
        .new_pos   (new_pos),
        .new_vel   (new_vel),
        .deflected (deflected)
    );

    assign new_pos_x = new_pos[0];
    assign new_pos_y = new_pos[1];
    assign new_pos_z = new_pos[2];
    assign new_vel_x = new_vel[0];
    assign new_vel_y = new_vel[1];
    assign new_vel_z = new_vel[2];

    // Every result follows its transfer in by the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 20))
        else $error("result without a matching transfer in");

    // A particle that does not hit leaves unchanged.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !deflected) |-> (new_pos_x == $past(pos_x, 20)
                                  && new_vel_z == $past(vel_z, 20)))
        else $error("pass-through result differs from its input");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Plane deflector testbench
// Streams particles through the deflector under several plane, bounce and
// time-step settings, predicts every result in fixed point and compares the
// results in order, with random gaps on the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int  LATENCY   = 20;
    localparam longint LIMIT  = 400000;
    localparam longint WMAX   = 64'sd2147483647;
    localparam longint WMIN   = -64'sd2147483648;

    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz;
    } particle_t;

    typedef struct {
        logic [31:0] px, py, pz, vx, vy, vz;
        logic        hit;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic done;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic deflected;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ppd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    particle_t pending_q[$];
    outcome_t  expected_q[$];
    longint    plane_reg[8];
    int        idle_pct = 0;
    int        errors = 0;
    int        checked = 0;
    int        hits = 0;
    longint    cycles = 0;
    bit        driving = 0;

    always #10 clk = ~clk;

    particle_plane_deflector dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .done(done), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
        .new_pos_z(new_pos_z), .new_vel_x(new_vel_x), .new_vel_y(new_vel_y),
        .new_vel_z(new_vel_z), .deflected(deflected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic longint clamp(input logic signed [127:0] v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return longint'(v);
    endfunction

    // Fixed-point product with floor rounding, saturated.
    function automatic longint qmul(input longint a, input longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clamp(p >>> ppd_pkg::FRAC_BITS);
    endfunction

    function automatic longint qdiv(input longint num, input longint den);
        logic signed [127:0] n, q;
        n = 128'(num) <<< ppd_pkg::FRAC_BITS;
        q = n / 128'(den);
        return clamp(q);
    endfunction

    function automatic longint sx(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic outcome_t deflect(input particle_t p);
        outcome_t o;
        longint ps[3], vl[3], dr[3], mv[3], nr[3];
        longint pd, after, prior, a, den, frac, vd, hp, r;
        ps[0] = sx(p.px); ps[1] = sx(p.py); ps[2] = sx(p.pz);
        vl[0] = sx(p.vx); vl[1] = sx(p.vy); vl[2] = sx(p.vz);
        for (int i = 0; i < 3; i++) nr[i] = plane_reg[i];
        o.px = p.px; o.py = p.py; o.pz = p.pz;
        o.vx = p.vx; o.vy = p.vy; o.vz = p.vz; o.hit = 1'b0;
        pd = clamp(-(qmul(nr[0], plane_reg[3]) + qmul(nr[1], plane_reg[4])
                     + qmul(nr[2], plane_reg[5])));
        for (int i = 0; i < 3; i++)
        begin
            dr[i] = qmul(vl[i], plane_reg[7]);
            mv[i] = clamp(ps[i] + dr[i]);
        end
        after = qmul(nr[0], mv[0]) + qmul(nr[1], mv[1]) + qmul(nr[2], mv[2]) + pd;
        prior = qmul(nr[0], ps[0]) + qmul(nr[1], ps[1]) + qmul(nr[2], ps[2]) + pd;
        if (after <= 0 && prior > 0)
        begin
            a = clamp(prior);
            den = clamp(qmul(dr[0], nr[0]) + qmul(dr[1], nr[1]) + qmul(dr[2], nr[2]));
            frac = (den == 0) ? WMAX : qdiv(-a, den);
            vd = clamp(qmul(vl[0], nr[0]) + qmul(vl[1], nr[1]) + qmul(vl[2], nr[2]));
            for (int i = 0; i < 3; i++)
            begin
                hp = qmul(dr[i], frac);
                ps[i] = clamp(ps[i] + hp + qmul(hp - dr[i], plane_reg[6]));
                r = vl[i] - 2 * qmul(vd, nr[i]);
                vl[i] = qmul(r, plane_reg[6]);
            end
            o.px = ps[0][31:0]; o.py = ps[1][31:0]; o.pz = ps[2][31:0];
            o.vx = vl[0][31:0]; o.vy = vl[1][31:0]; o.vz = vl[2][31:0];
            o.hit = 1'b1;
        end
        return o;
    endfunction

    // Driver: one transfer per cycle at most, gaps per idle_pct.
    always @(negedge clk)
    begin
        if (driving && pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            particle_t p;
            p = pending_q.pop_front();
            pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
            vel_x <= p.vx; vel_y <= p.vy; vel_z <= p.vz;
            start <= 1'b1;
            expected_q.push_back(deflect(p));
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        if (rst_n && start && busy)
        begin
            errors = errors + 1;
            $display("busy raised during a transfer");
        end
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                errors = errors + 1;
                $display("result with nothing expected");
            end
            else
            begin
                outcome_t e;
                e = expected_q.pop_front();
                checked <= checked + 1;
                hits <= hits + e.hit;
                if (e.px !== new_pos_x || e.py !== new_pos_y || e.pz !== new_pos_z ||
                    e.vx !== new_vel_x || e.vy !== new_vel_y || e.vz !== new_vel_z ||
                    e.hit !== deflected)
                begin
                    if (errors < 10)
                        $display("mismatch: exp %h %h %h / %h %h %h / %b got %h %h %h / %h %h %h / %b",
                                 e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.hit,
                                 new_pos_x, new_pos_y, new_pos_z,
                                 new_vel_x, new_vel_y, new_vel_z, deflected);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic write_reg(input logic [ppd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == ppd_pkg::CFG_TSTEP) plane_reg[idx] = longint'(val[30:0]);
        else plane_reg[idx] = sx(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        driving = 1;
        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
        driving = 0;
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Random 32-bit value biased toward small magnitudes and the extremes.
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
        endcase
    endfunction

    // Particle placed above the plane y = ay, typically heading through it.
    function automatic particle_t aimed();
        particle_t p;
        p.px = rnd_word(); p.pz = rnd_word(); p.vx = rnd_word(); p.vz = rnd_word();
        p.py = 32'(plane_reg[4] + $urandom_range(8 << 16) + 1);
        p.vy = 32'(-$signed($urandom_range(64 << 16)));
        if ($urandom_range(9) == 0) p.vy = $urandom();
        return p;
    endfunction

    function automatic particle_t noise();
        particle_t p;
        p.px = $urandom(); p.py = $urandom(); p.pz = $urandom();
        p.vx = $urandom(); p.vy = $urandom(); p.vz = $urandom();
        return p;
    endfunction

    task automatic setting(input logic [31:0] nx, ny, nz, ax, ay, az, bf, ts);
        write_reg(ppd_pkg::CFG_NORMAL_X, nx); write_reg(ppd_pkg::CFG_NORMAL_Y, ny);
        write_reg(ppd_pkg::CFG_NORMAL_Z, nz); write_reg(ppd_pkg::CFG_ANCHOR_X, ax);
        write_reg(ppd_pkg::CFG_ANCHOR_Y, ay); write_reg(ppd_pkg::CFG_ANCHOR_Z, az);
        write_reg(ppd_pkg::CFG_BOUNCE, bf);   write_reg(ppd_pkg::CFG_TSTEP, ts);
    endtask

    initial
    begin
        particle_t p;
        plane_reg = '{0, 65536, 0, 0, 0, 0, 0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults pass everything through (time step zero).
        pending_q.push_back('{32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 1});
        drain();
        setting(0, 32'h00010000, 0, 0, 0, 0, 32'h0000c000, 32'h00010000);
        pending_q.push_back('{0, 32'h00020000, 0, 32'h00010000, 32'hfffc0000, 0}); // hit
        pending_q.push_back('{0, 32'h00020000, 0, 0, 32'hfffe0000, 0}); // lands on plane
        pending_q.push_back('{0, 0, 0, 0, 32'hffff0000, 0});            // starts on plane
        pending_q.push_back('{0, 32'hfffe0000, 0, 0, 32'h00040000, 0}); // from below
        pending_q.push_back('{0, 32'h00020000, 0, 0, 32'h00010000, 0}); // moving away
        pending_q.push_back('{32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h7fffffff});
        pending_q.push_back('{0, 1, 0, 0, 32'hffffffff, 0});             // tiny step
        drain();
        // Extremes: negative bounce, huge time step, skewed non-unit normal.
        setting(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        for (int i = 0; i < 8; i++) pending_q.push_back(noise());
        pending_q.push_back('{0, 32'h00010000, 0, 0, 32'hffff0000, 0});
        drain();

        // Random phases with different settings and idle rates.
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [31:0] nrmv[3];
            int k;
            k = $urandom_range(2);
            for (int i = 0; i < 3; i++) nrmv[i] = 0;
            nrmv[k] = (ph % 2) ? 32'hffff0000 : 32'h00010000;
            if (ph == 6) for (int i = 0; i < 3; i++) nrmv[i] = 32'h0000b505 * (i != k);
            if (ph == 7) for (int i = 0; i < 3; i++) nrmv[i] = $urandom();
            setting(nrmv[0], (ph < 2) ? 32'h00010000 : nrmv[1], nrmv[2],
                    rnd_word(), 32'($signed($urandom_range(8 << 16)) - (4 << 16)),
                    rnd_word(), (ph == 3) ? 32'h7fffffff : $urandom_range(1 << 17),
                    (ph == 4) ? 32'h7fffffff : $urandom_range(1 << 16));
            idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 64 : (ph % 4 == 2) ? 64 : 29;
            for (int i = 0; i < 118; i++)
            begin
                p = ($urandom_range(9) < 7) ? aimed() : noise();
                pending_q.push_back(p);
            end
            drain();
        end

        $display("checked %0d particles, %0d deflected, over 11 plane settings",
                 checked, hits);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_front.sv
hw/rtl/ppd_div.sv
hw/rtl/ppd_back.sv
hw/rtl/particle_plane_deflector.sv
tb/sv/testbench.sv
